// ===== hw/rtl/sgag_pkg.sv =====
// Shared types, widths and register codes for the strided gather address generator.
// No dependencies; imported by sgag_cell and strided_gather_address_generator.
`timescale 1ns / 1ps

package sgag_pkg;

  localparam int DIMS            = 3;
  localparam int MAX_DIMS_DEF    = 3;
  localparam int EXTENT_BITS_DEF = 16;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int BASE_W    = 32;
  localparam int EB_W      = 4;
  localparam int EXT_W     = 16;
  localparam int STRIDE_W  = 32;
  localparam int SRC_W     = 50;
  localparam int EMIT_W    = 48;
  localparam int OFS_W     = 56;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_OFFSET   = 3'd0,
    REG_ELEM_BYTES    = 3'd1,
    REG_EXTENT_OUTER  = 3'd2,
    REG_EXTENT_MIDDLE = 3'd3,
    REG_EXTENT_INNER  = 3'd4,
    REG_STRIDE_OUTER  = 3'd5,
    REG_STRIDE_MIDDLE = 3'd6,
    REG_STRIDE_INNER  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic accept;
    logic restart;
    logic en1;
    logic en2;
  } sgag_ctrl_t;

  typedef struct packed {
    logic not_end;
    logic zero_ext;
  } sgag_stat_t;

endpackage

// ===== hw/rtl/strided_gather_address_generator.sv =====
// Top level of the strided gather address generator: configuration registers,
// odometer control, cell chain and offset pipeline. Depends on sgag_pkg, sgag_cell.
// Usage:
//   Write the eight registers through cfg_we / cfg_index / cfg_wdata while idle.
//   Each input beat carries in_restart; 1 starts a new walk, 0 takes the next
//   element. Every input beat yields exactly one output beat, in order.
//   Output beat: out_valid_res, source and destination byte offsets, out_last.
//   After the walk ends, or with any extent zero, out_valid_res is 0 and the
//   other fields are 0.
// Pipeline: an accepted beat passes five registered stages before out_valid.
// Throughput: one beat per cycle while out_stall is low; the counter update of the
//   cell chain is combinational, the multiply and sums sit in later pipeline stages.
// Stall: each stage holds only while the one after it is full, so bubbles
//   collapse; in_stall rises once all five stages hold beats behind a stalled
//   output.
// Reset: registers return to base 0, element size 1, extents 1, strides 0,0,1;
//   counters clear, no walk is active and the pipeline empties.
`timescale 1ns / 1ps

module strided_gather_address_generator #(
  parameter int MAX_DIMS    = sgag_pkg::MAX_DIMS_DEF,
  parameter int EXTENT_BITS = sgag_pkg::EXTENT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sgag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgag_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_restart,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_valid_res,
  output logic [sgag_pkg::OFS_W-1:0]      out_src_byte_offset,
  output logic [sgag_pkg::OFS_W-1:0]      out_dst_byte_offset,
  output logic                            out_last
);
  import sgag_pkg::*;

  localparam int CNT_W  = (EXTENT_BITS < EXT_W) ? EXTENT_BITS : EXT_W;
  localparam int PROD_W = CNT_W + STRIDE_W;

  logic [BASE_W-1:0]   base_r;
  logic [EB_W-1:0]     eb_r;
  logic [EXT_W-1:0]    extent_r [DIMS];
  logic [STRIDE_W-1:0] stride_r [DIMS];

  logic [EXT_W-1:0]    ext_eff    [DIMS];
  logic [STRIDE_W-1:0] stride_eff [DIMS];
  logic [PROD_W-1:0]   prod       [DIMS];
  sgag_stat_t          stat       [DIMS];
  logic [DIMS:0]       carry;
  logic [DIMS-1:0]     not_end_v, zero_v;
  sgag_ctrl_t          ctrl;

  logic                acc, en1, en2, en3, en4, en5;
  logic                is_last, empty, ok, done_eff;
  logic                done_r, done_nxt;
  logic [EMIT_W-1:0]   em_r, em_nxt, em_eff;

  logic                v1_r, v2_r, v3_r, v4_r, v5_r;
  logic                ok1_r, ok2_r, ok3_r, ok4_r;
  logic                last1_r, last2_r, last3_r, last4_r;
  logic [EMIT_W-1:0]   em1_r, em2_r, em3_r, em4_r;
  logic [SRC_W-1:0]    a3_r, b3_r, src4_r;
  logic                vres5_r, last5_r;
  logic [OFS_W-1:0]    src5_r, dst5_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      eb_r        <= EB_W'(1);
      extent_r[0] <= EXT_W'(1);
      extent_r[1] <= EXT_W'(1);
      extent_r[2] <= EXT_W'(1);
      stride_r[0] <= '0;
      stride_r[1] <= '0;
      stride_r[2] <= STRIDE_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BASE_OFFSET:   base_r      <= cfg_wdata[BASE_W-1:0];
        REG_ELEM_BYTES:    eb_r        <= cfg_wdata[EB_W-1:0];
        REG_EXTENT_OUTER:  extent_r[0] <= cfg_wdata[EXT_W-1:0];
        REG_EXTENT_MIDDLE: extent_r[1] <= cfg_wdata[EXT_W-1:0];
        REG_EXTENT_INNER:  extent_r[2] <= cfg_wdata[EXT_W-1:0];
        REG_STRIDE_OUTER:  stride_r[0] <= cfg_wdata[STRIDE_W-1:0];
        REG_STRIDE_MIDDLE: stride_r[1] <= cfg_wdata[STRIDE_W-1:0];
        REG_STRIDE_INNER:  stride_r[2] <= cfg_wdata[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow
  assign en5      = !v5_r || !out_stall;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;
  assign acc      = in_valid && en1;

  assign ctrl.accept  = acc;
  assign ctrl.restart = in_restart;
  assign ctrl.en1     = en1;
  assign ctrl.en2     = en2;

  // cell chain, outer dimension first
  for (genvar d = 0; d < DIMS; d++) begin : g_dim
    assign ext_eff[d]    = (d >= DIMS - MAX_DIMS) ? extent_r[d] : EXT_W'(1);
    assign stride_eff[d] = (d >= DIMS - MAX_DIMS) ? stride_r[d] : '0;
    assign not_end_v[d]  = stat[d].not_end;
    assign zero_v[d]     = stat[d].zero_ext;

    sgag_cell #(.CNT_W(CNT_W)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .ext       (ext_eff[d]),
      .stride    (stride_eff[d]),
      .carry_in  (carry[d+1]),
      .carry_out (carry[d]),
      .stat      (stat[d]),
      .prod      (prod[d])
    );
  end

  assign is_last    = ~|not_end_v;
  assign empty      = |zero_v;
  assign done_eff   = (in_restart ? 1'b0 : done_r) || empty;
  assign ok         = !done_eff;
  assign carry[DIMS] = acc && ok && !is_last;

  assign em_eff   = in_restart ? '0 : em_r;
  assign em_nxt   = ok ? em_eff + EMIT_W'(1) : em_eff;
  assign done_nxt = !ok || is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b1;
      em_r   <= '0;
    end else if (acc) begin
      done_r <= done_nxt;
      em_r   <= em_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ok1_r   <= ok;
      last1_r <= is_last;
      em1_r   <= em_eff;
    end
    if (en2) begin
      ok2_r   <= ok1_r;
      last2_r <= last1_r;
      em2_r   <= em1_r;
    end
    if (en3) begin
      ok3_r   <= ok2_r;
      last3_r <= last2_r;
      em3_r   <= em2_r;
      a3_r    <= SRC_W'(base_r) + SRC_W'(prod[0]);
      b3_r    <= SRC_W'(prod[1]) + SRC_W'(prod[2]);
    end
    if (en4) begin
      ok4_r   <= ok3_r;
      last4_r <= last3_r;
      em4_r   <= em3_r;
      src4_r  <= a3_r + b3_r;
    end
    if (en5) begin
      vres5_r <= ok4_r;
      last5_r <= ok4_r && last4_r;
      src5_r  <= ok4_r ? OFS_W'(src4_r) * OFS_W'(eb_r) : '0;
      dst5_r  <= ok4_r ? OFS_W'(em4_r) * OFS_W'(eb_r) : '0;
    end
  end

  assign out_valid           = v5_r;
  assign out_valid_res       = vres5_r;
  assign out_last            = last5_r;
  assign out_src_byte_offset = src5_r;
  assign out_dst_byte_offset = dst5_r;

  a_no_outer_carry: assert property (@(posedge clk) disable iff (!rst_n)
    !carry[0])
    else $error("odometer carried past the outer dimension");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    acc && ok && is_last |=> done_r)
    else $error("walk not closed after its last element");

  a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_restart && !empty |=> em_r == EMIT_W'(1))
    else $error("element count wrong after restart");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r && v2_r && v3_r && v4_r && v5_r && out_stall)
    else $error("input held while the pipeline has room");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |->
      out_src_byte_offset == '0 && out_dst_byte_offset == '0 && !out_last)
    else $error("invalid result carries nonzero fields");

endmodule

// ===== hw/rtl/sgag_cell.sv =====
// One dimension of the odometer: counter, carry to the next slower cell, and the
// pipelined counter-times-stride product. Depends on sgag_pkg.
`timescale 1ns / 1ps

module sgag_cell #(
  parameter int CNT_W = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  sgag_pkg::sgag_ctrl_t                  ctrl,
  input  logic [sgag_pkg::EXT_W-1:0]            ext,
  input  logic [sgag_pkg::STRIDE_W-1:0]         stride,
  input  logic                                  carry_in,
  output logic                                  carry_out,
  output sgag_pkg::sgag_stat_t                  stat,
  output logic [CNT_W+sgag_pkg::STRIDE_W-1:0]   prod
);
  import sgag_pkg::*;

  localparam int PROD_W = CNT_W + STRIDE_W;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt, c_eff, c1_r;
  logic [CNT_W:0]    c_inc, ext_eff;
  logic [PROD_W-1:0] prod_r;

  assign c_eff   = ctrl.restart ? '0 : cnt_r;
  assign c_inc   = {1'b0, c_eff} + {{CNT_W{1'b0}}, 1'b1};
  assign ext_eff = {1'b0, ext[CNT_W-1:0]};

  assign stat.not_end  = c_inc < ext_eff;
  assign stat.zero_ext = ext[CNT_W-1:0] == '0;
  assign carry_out     = carry_in && !stat.not_end;

  always_comb begin
    if (carry_in) begin
      cnt_nxt = stat.not_end ? c_inc[CNT_W-1:0] : '0;
    end else begin
      cnt_nxt = c_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctrl.accept) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en1) begin
      c1_r <= c_eff;
    end
    if (ctrl.en2) begin
      prod_r <= {{STRIDE_W{1'b0}}, c1_r} * {{CNT_W{1'b0}}, stride};
    end
  end

  assign prod = prod_r;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for strided_gather_address_generator: directed and random
// odometer walks, each output beat checked against an in-bench walk predictor.
// Depends on sgag_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;
  import sgag_pkg::*;

  localparam int PIPE_LAT = 5;
  localparam logic [63:0] SRC_ELEM_MASK = (64'd1 << SRC_W) - 64'd1;

  typedef struct packed {
    logic             valid_res;
    logic [OFS_W-1:0] src;
    logic [OFS_W-1:0] dst;
    logic             last;
  } addr_beat_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_BASE_OFFSET;
  logic [CFG_W-1:0]     cfg_wdata  = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic                 in_restart = 1'b0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic                 out_valid_res;
  logic [OFS_W-1:0]     out_src_byte_offset;
  logic [OFS_W-1:0]     out_dst_byte_offset;
  logic                 out_last;

  strided_gather_address_generator dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_restart          (in_restart),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_valid_res       (out_valid_res),
    .out_src_byte_offset (out_src_byte_offset),
    .out_dst_byte_offset (out_dst_byte_offset),
    .out_last            (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // view registers and walk state as the block should hold them
  logic [BASE_W-1:0]   view_base;
  logic [EB_W-1:0]     view_eb;
  logic [EXT_W-1:0]    view_ext [DIMS];
  logic [STRIDE_W-1:0] view_stride [DIMS];
  logic [EXT_W-1:0]    walk_ctr [DIMS];
  logic [EMIT_W-1:0]   walk_emitted;
  logic                walk_done;

  addr_beat_t  pending_addrs[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned beats_sent    = 0;
  int unsigned beats_checked = 0;
  int unsigned walks_closed  = 0;
  int unsigned regs_written  = 0;
  int unsigned faults        = 0;

  function automatic void reset_walk_model();
    int d;
    view_base = '0;
    view_eb   = 4'd1;
    for (d = 0; d < DIMS; d++) begin
      view_ext[d]    = 16'd1;
      view_stride[d] = '0;
      walk_ctr[d]    = '0;
    end
    view_stride[DIMS-1] = 32'd1;
    walk_emitted = '0;
    walk_done    = 1'b1;
  endfunction

  function automatic addr_beat_t advance_walk(input logic restart);
    addr_beat_t  r;
    logic [63:0] elem;
    logic [63:0] c;
    logic        at_end;
    logic        carry;
    int          d;
    r = '0;
    if (restart) begin
      for (d = 0; d < DIMS; d++) walk_ctr[d] = '0;
      walk_emitted = '0;
      walk_done    = 1'b0;
    end
    for (d = 0; d < DIMS; d++) if (view_ext[d] == '0) walk_done = 1'b1;
    if (!walk_done) begin
      elem   = 64'(view_base);
      at_end = 1'b1;
      for (d = 0; d < DIMS; d++) begin
        c    = 64'(walk_ctr[d]);
        elem = elem + c * 64'(view_stride[d]);
        if (c + 64'd1 < 64'(view_ext[d])) at_end = 1'b0;
      end
      elem        = elem & SRC_ELEM_MASK;
      r.valid_res = 1'b1;
      r.src       = OFS_W'(elem * 64'(view_eb));
      r.dst       = OFS_W'(64'(walk_emitted) * 64'(view_eb));
      r.last      = at_end;
      walk_emitted = walk_emitted + EMIT_W'(1);
      if (at_end) begin
        walk_done = 1'b1;
      end else begin
        carry = 1'b1;
        for (d = DIMS - 1; d >= 0; d--) begin
          if (carry) begin
            c = 64'(walk_ctr[d]);
            if (c + 64'd1 < 64'(view_ext[d])) begin
              walk_ctr[d] = walk_ctr[d] + EXT_W'(1);
              carry = 1'b0;
            end else begin
              walk_ctr[d] = '0;
            end
          end
        end
      end
    end
    return r;
  endfunction

  function automatic void note_fault(input string what);
    if (faults < 10) $display("%0t mismatch: %s", $time, what);
    faults++;
  endfunction

  function automatic void check_addr_beat();
    addr_beat_t want;
    if (pending_addrs.size() == 0) begin
      note_fault($sformatf("beat with nothing pending, src %h", out_src_byte_offset));
    end else begin
      want = pending_addrs.pop_front();
      beats_checked++;
      if (out_valid_res !== want.valid_res)
        note_fault($sformatf("valid_res exp %b got %b", want.valid_res, out_valid_res));
      if (out_src_byte_offset !== want.src)
        note_fault($sformatf("src offset exp %h got %h", want.src, out_src_byte_offset));
      if (out_dst_byte_offset !== want.dst)
        note_fault($sformatf("dst offset exp %h got %h", want.dst, out_dst_byte_offset));
      if (out_last !== want.last)
        note_fault($sformatf("last exp %b got %b", want.last, out_last));
      if (want.last) walks_closed++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) check_addr_beat();
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_BASE_OFFSET:   view_base      = v[BASE_W-1:0];
      REG_ELEM_BYTES:    view_eb        = v[EB_W-1:0];
      REG_EXTENT_OUTER:  view_ext[0]    = v[EXT_W-1:0];
      REG_EXTENT_MIDDLE: view_ext[1]    = v[EXT_W-1:0];
      REG_EXTENT_INNER:  view_ext[2]    = v[EXT_W-1:0];
      REG_STRIDE_OUTER:  view_stride[0] = v[STRIDE_W-1:0];
      REG_STRIDE_MIDDLE: view_stride[1] = v[STRIDE_W-1:0];
      REG_STRIDE_INNER:  view_stride[2] = v[STRIDE_W-1:0];
      default: ;
    endcase
    regs_written++;
    @(posedge clk);
  endtask

  task automatic program_view(input logic [31:0] base, input logic [31:0] eb,
                              input logic [31:0] eo, input logic [31:0] em,
                              input logic [31:0] ei, input logic [31:0] so,
                              input logic [31:0] sm, input logic [31:0] si);
    cfg_write(REG_BASE_OFFSET, base);
    cfg_write(REG_ELEM_BYTES, eb);
    cfg_write(REG_EXTENT_OUTER, eo);
    cfg_write(REG_EXTENT_MIDDLE, em);
    cfg_write(REG_EXTENT_INNER, ei);
    cfg_write(REG_STRIDE_OUTER, so);
    cfg_write(REG_STRIDE_MIDDLE, sm);
    cfg_write(REG_STRIDE_INNER, si);
    cfg_we <= 1'b0;
  endtask

  task automatic send_beat(input logic restart);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_addrs = {pending_addrs, advance_walk(restart)};
    beats_sent++;
  endtask

  // drop valid, wait for every pending beat, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_addrs.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  function automatic logic [EXT_W-1:0] pick_extent();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2:       return EXT_W'($urandom_range(5, 65535));
      default: return EXT_W'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return 32'($urandom_range(1, 16));
      default: return $urandom();
    endcase
  endfunction

  task automatic program_random_view(output logic [63:0] span);
    logic [EXT_W-1:0] e [DIMS];
    logic [EB_W-1:0]  eb;
    int               d;
    for (d = 0; d < DIMS; d++) e[d] = pick_extent();
    eb = ($urandom_range(0, 9) == 0) ? EB_W'($urandom_range(0, 15))
                                     : EB_W'($urandom_range(1, 8));
    program_view(pick_word(), {28'($urandom()), eb}, {16'($urandom()), e[0]},
                 {16'($urandom()), e[1]}, {16'($urandom()), e[2]},
                 pick_word(), pick_word(), pick_word());
    span = 64'(e[0]) * 64'(e[1]) * 64'(e[2]);
  endtask

  task automatic test_idle_walk();
    send_beat(1'b0);
    send_beat(1'b1);
    send_beat(1'b0);
    settle();
  endtask

  task automatic test_field_extremes();
    program_view(32'hFFFF_FFFF, 32'd15, 32'd2, 32'd2, 32'd2,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(1'b1);
    repeat (8) send_beat(1'b0);
    settle();
    program_view(32'd0, 32'd0, 32'hFFFF, 32'hFFFF, 32'hFFFF,
                 32'hFFFF_FFFF, 32'd0, 32'd1);
    send_beat(1'b1);
    send_beat(1'b0);
    settle();
  endtask

  task automatic test_empty_view();
    int d;
    for (d = 0; d < DIMS; d++) begin
      program_view(32'd7, 32'd4, (d == 0) ? 32'd0 : 32'd3, (d == 1) ? 32'd0 : 32'd3,
                   (d == 2) ? 32'd0 : 32'd3, 32'd1, 32'd1, 32'd1);
      send_beat(1'b1);
      settle();
    end
    send_beat(1'b0);
    settle();
  endtask

  task automatic test_reconfig_mid_walk();
    program_view(32'd100, 32'd2, 32'd2, 32'd3, 32'd3, 32'd1000, 32'd10, 32'd1);
    send_beat(1'b1);
    repeat (4) send_beat(1'b0);
    settle();
    // shrink under a live walk: inner counter now sits beyond its extent
    program_view(32'd100, 32'd2, 32'd2, 32'd2, 32'd2, 32'd1000, 32'd10, 32'd1);
    repeat (6) send_beat(1'b0);
    settle();
  endtask

  task automatic test_random_walks(input int unsigned snd_pct, input int unsigned rcv_pct,
                                   input int unsigned n_beats);
    int unsigned first;
    int unsigned steps;
    int unsigned k;
    logic [63:0] span;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    first = beats_sent;
    while (beats_sent - first < n_beats) begin
      program_random_view(span);
      repeat ($urandom_range(1, 3)) begin
        if (span == 0)
          steps = $urandom_range(1, 3);
        else if (span > 40)
          steps = $urandom_range(1, 8);
        else if ($urandom_range(0, 9) == 0)
          steps = $urandom_range(1, int'(span));
        else
          steps = int'(span) + $urandom_range(0, 2);
        // now and then carry on the previous walk under the new view
        send_beat($urandom_range(0, 5) != 0);
        for (k = 1; k < steps; k++) send_beat($urandom_range(0, 39) == 0);
      end
      settle();
    end
  endtask

  initial begin
    reset_walk_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_walk();
    test_field_extremes();
    test_empty_view();
    test_reconfig_mid_walk();
    test_random_walks(31, 48, 460);
    test_random_walks(48, 31, 460);
    test_random_walks(0, 0, 460);
    settle();
    repeat (PIPE_LAT * 4) @(posedge clk);
    $display("covered %0d beats in %0d checks, %0d walks ended on a last beat",
             beats_sent, beats_checked, walks_closed);
    $display("register writes %0d, mismatches %0d", regs_written, faults);
    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d beats pending", pending_addrs.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
